FILE: rtl/isa_pkg.sv
// ----------------------------------------------------------------------------
// isa_pkg
// Shared types and constants for the indexed shift array.
// ----------------------------------------------------------------------------
`default_nettype none

package isa_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int IDX_W      = $clog2(DEPTH + 1);
	localparam int KIND_W     = 2;
	localparam int STATUS_W   = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_READ   = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// per-cell update controls; at most one is high
	typedef struct packed {
		logic load;
		logic shift_up;
		logic shift_down;
	} cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/isa_req_if.sv
// ----------------------------------------------------------------------------
// isa_req_if
// Operation channel: valid/ready handshake with kind, index and value.
// ----------------------------------------------------------------------------
`default_nettype none

interface isa_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [4:0]  index;
	logic [31:0] value;

	modport source (output valid, output kind, output index, output value, input ready);
	modport sink   (input valid, input kind, input index, input value, output ready);
endinterface

`default_nettype wire

FILE: rtl/isa_rsp_if.sv
// ----------------------------------------------------------------------------
// isa_rsp_if
// Result channel: valid/ready handshake with read data, status and count.
// ----------------------------------------------------------------------------
`default_nettype none

interface isa_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_value;
	logic [1:0]  status;
	logic [4:0]  count;
	logic        empty_res;

	modport source (output valid, output read_value, output status, output count,
		output empty_res, input ready);
	modport sink   (input valid, input read_value, input status, input count,
		input empty_res, output ready);
endinterface

`default_nettype wire

FILE: rtl/indexed_shift_array_core.sv
// ----------------------------------------------------------------------------
// indexed_shift_array_core
// Ordered list of up to DEPTH entries with insert, remove and read at index.
// ----------------------------------------------------------------------------
//
//   channel | direction | payload
//   --------+-----------+------------------------------------------
//   req     | in        | kind, index, value
//   rsp     | out       | read_value, status, count, empty_res
//
// One transfer on req gives one transfer on rsp; the result is registered.
// A new operation is taken every cycle while rsp keeps up; the row of entry
// cells shifts in parallel, each cell taking its neighbour at the same edge.
// The result register sits between the two sides: req is ready whenever that
// register is empty or being drained by rsp in the same cycle.
// arst_n clears the count and the result valid; entry contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_shift_array_core (
	input  wire logic clk,
	input  wire logic arst_n,
	isa_req_if.sink   req,
	isa_rsp_if.source rsp
);
	import isa_pkg::*;

	logic [IDX_W-1:0]      count_q;
	logic [DATA_WIDTH-1:0] cell_q [DEPTH];
	cell_ctrl_t            ctrl   [DEPTH];

	logic                  rsp_valid_q;
	logic [DATA_WIDTH-1:0] read_value_q;
	status_t               status_q;
	logic [IDX_W-1:0]      count_out_q;

	logic                  xfer;
	logic                  do_insert;
	logic                  do_remove;
	status_t               status_d;
	logic [DATA_WIDTH-1:0] read_value_d;
	logic [IDX_W-1:0]      count_d;

	// take a new operation when the result register is free or being taken
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign xfer      = req.valid && req.ready;

	// decode the operation against the current count
	always_comb begin
		do_insert    = 1'b0;
		do_remove    = 1'b0;
		status_d     = ST_OK;
		read_value_d = '0;
		count_d      = count_q;
		case (req.kind)
			KIND_INSERT: begin
				// fullness wins over a bad index
				if (count_q == IDX_W'(DEPTH)) begin
					status_d = ST_FULL;
				end else if (req.index > count_q) begin
					status_d = ST_RANGE;
				end else begin
					do_insert = 1'b1;
					count_d   = count_q + 1'b1;
				end
			end
			KIND_REMOVE: begin
				if (req.index >= count_q) begin
					status_d = ST_RANGE;
				end else begin
					do_remove = 1'b1;
					count_d   = count_q - 1'b1;
				end
			end
			KIND_READ: begin
				if (req.index >= count_q) begin
					status_d = ST_RANGE;
				end else begin
					read_value_d = cell_q[req.index[ADDR_W-1:0]];
				end
			end
			default: begin
				// unused kind code: reject as a bad request
				status_d = ST_RANGE;
			end
		endcase
	end

	// row of entry cells; cell i takes cell i-1 on insert, cell i+1 on remove
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] below;
		logic [DATA_WIDTH-1:0] above;

		if (i == 0) begin : g_first
			assign below = '0;
		end else begin : g_below
			assign below = cell_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign above = '0;
		end else begin : g_above
			assign above = cell_q[i+1];
		end

		always_comb begin
			ctrl[i].load       = xfer && do_insert && (req.index == IDX_W'(i));
			ctrl[i].shift_up   = xfer && do_insert && (req.index <  IDX_W'(i));
			ctrl[i].shift_down = xfer && do_remove && (req.index <= IDX_W'(i));
		end

		isa_cell u_cell (
			.clk   (clk),
			.ctrl  (ctrl[i]),
			.below (below),
			.above (above),
			.value (req.value[DATA_WIDTH-1:0]),
			.q     (cell_q[i])
		);
	end

	// count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (xfer) begin
				count_q <= count_d;
			end
			if (xfer) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result payload; hold while stalled
	always_ff @(posedge clk) begin
		if (xfer) begin
			read_value_q <= read_value_d;
			status_q     <= status_d;
			count_out_q  <= count_d;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = 32'(read_value_q);
	assign rsp.status     = status_q;
	assign rsp.count      = 5'(count_out_q);
	assign rsp.empty_res  = (count_out_q == '0);

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= IDX_W'(DEPTH))
		else $error("entry count above depth");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && do_insert |=> count_q == $past(count_q) + 1'b1)
		else $error("accepted insert did not grow the count");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && do_remove |=> count_q == $past(count_q) - 1'b1)
		else $error("accepted remove did not shrink the count");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q != ST_OK |-> read_value_q == '0)
		else $error("failed operation returned non-zero data");

	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		xfer |=> count_out_q == count_q)
		else $error("reported count differs from stored count");
`endif

endmodule

`default_nettype wire

FILE: rtl/isa_cell.sv
// ----------------------------------------------------------------------------
// isa_cell
// One list entry: load a new value, take the lower or upper neighbour, or hold.
// ----------------------------------------------------------------------------
`default_nettype none

module isa_cell (
	input  wire logic                           clk,
	input  wire isa_pkg::cell_ctrl_t            ctrl,
	input  wire logic [isa_pkg::DATA_WIDTH-1:0] below,
	input  wire logic [isa_pkg::DATA_WIDTH-1:0] above,
	input  wire logic [isa_pkg::DATA_WIDTH-1:0] value,
	output logic      [isa_pkg::DATA_WIDTH-1:0] q
);
	import isa_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= value;
		end else if (ctrl.shift_up) begin
			data_q <= below;
		end else if (ctrl.shift_down) begin
			data_q <= above;
		end
	end

	assign q = data_q;

endmodule

`default_nettype wire

FILE: sim/indexed_shift_array_core_tb.sv
// ----------------------------------------------------------------------------
// indexed_shift_array_core_tb
// Self-checking bench for the indexed shift array: insert, remove and read at
// an index on a list of up to DEPTH entries. A short table of hand-picked
// operations runs first, then several hundred random operations that sweep
// the list between empty and full. Every result is checked against its
// pinned table row or a behavioural list model kept in the bench, with
// random idling on both channels and one long result back-pressure stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_shift_array_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import isa_pkg::*;

	// kind code left unused by the block; it must answer with a range status
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	localparam int DIRECTED_OPS  = 25;
	localparam int RANDOM_OPS    = 725;
	localparam int IDLE_PCT      = 13;
	// no idling on either side while this many transfers are in this window
	localparam int QUIET_FIRST   = 300;
	localparam int QUIET_LAST    = 420;
	// result side holds ready low for this long once the trigger count passes
	localparam int HOLD_TRIGGER  = 150;
	localparam int HOLD_CYCLES   = 48;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] read_value;
		status_t               status;
		logic [IDX_W-1:0]      count;
		logic                  empty_res;
	} list_result_t;

	typedef struct {
		logic [KIND_W-1:0]     kind;
		logic [IDX_W-1:0]      index;
		logic [DATA_WIDTH-1:0] value;
		bit                    pinned;
		list_result_t          pin;
	} list_op_t;

	logic clk;
	logic arst_n;

	isa_req_if req_if ();
	isa_rsp_if rsp_if ();

	indexed_shift_array_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// ------------------------------------------------------------------------
	// Directed operations. Rows with pinned set carry a result read straight
	// off the list rules; the rest are checked against the list model.
	// ------------------------------------------------------------------------
	list_op_t directed_ops [DIRECTED_OPS] = '{
		// empty list: every read, remove and off-end insert is out of range
		'{KIND_READ,   5'd0,  32'h0000_0000, 1'b1, '{32'h0, ST_RANGE, 5'd0, 1'b1}},
		'{KIND_REMOVE, 5'd0,  32'h0000_0000, 1'b1, '{32'h0, ST_RANGE, 5'd0, 1'b1}},
		'{KIND_INSERT, 5'd1,  32'h1234_5678, 1'b1, '{32'h0, ST_RANGE, 5'd0, 1'b1}},
		'{KIND_UNUSED, 5'd31, 32'hFFFF_FFFF, 1'b1, '{32'h0, ST_RANGE, 5'd0, 1'b1}},
		// first entry at the top of the value range, then read it back
		'{KIND_INSERT, 5'd0,  32'hFFFF_FFFF, 1'b1, '{32'h0, ST_OK, 5'd1, 1'b0}},
		'{KIND_READ,   5'd0,  32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, ST_OK, 5'd1, 1'b0}},
		// insert at head, append, insert in the middle
		'{KIND_INSERT, 5'd0,  32'h0000_0000, 1'b0, '0},
		'{KIND_INSERT, 5'd2,  32'hA5A5_A5A5, 1'b0, '0},
		'{KIND_INSERT, 5'd1,  32'h5A5A_5A5A, 1'b0, '0},
		// fill to DEPTH with a mix of appends, head and middle inserts
		'{KIND_INSERT, 5'd4,  32'h0000_0001, 1'b0, '0},
		'{KIND_INSERT, 5'd0,  32'h0000_0002, 1'b0, '0},
		'{KIND_INSERT, 5'd3,  32'h0000_0004, 1'b0, '0},
		'{KIND_INSERT, 5'd7,  32'h0000_0008, 1'b0, '0},
		'{KIND_INSERT, 5'd1,  32'h8000_0000, 1'b0, '0},
		'{KIND_INSERT, 5'd9,  32'h4000_0000, 1'b0, '0},
		'{KIND_INSERT, 5'd5,  32'h2000_0000, 1'b0, '0},
		'{KIND_INSERT, 5'd11, 32'h1000_0000, 1'b0, '0},
		'{KIND_INSERT, 5'd2,  32'hDEAD_BEEF, 1'b0, '0},
		'{KIND_INSERT, 5'd13, 32'hCAFE_F00D, 1'b0, '0},
		'{KIND_INSERT, 5'd14, 32'h0F0F_0F0F, 1'b0, '0},
		'{KIND_INSERT, 5'd15, 32'hF0F0_F0F0, 1'b0, '0},
		// full list: full wins over a bad index
		'{KIND_INSERT, 5'd0,  32'h7777_7777, 1'b1, '{32'h0, ST_FULL, 5'd16, 1'b0}},
		'{KIND_INSERT, 5'd31, 32'h7777_7777, 1'b1, '{32'h0, ST_FULL, 5'd16, 1'b0}},
		'{KIND_READ,   5'd15, 32'h0000_0000, 1'b0, '0},
		'{KIND_REMOVE, 5'd0,  32'h0000_0000, 1'b0, '0}
	};

	// ------------------------------------------------------------------------
	// List model and expected-result store
	// ------------------------------------------------------------------------
	logic [DATA_WIDTH-1:0] list_mem [DEPTH];
	int                    list_len;
	list_result_t          pending_results [$];

	// operation on the request lines; its pinned result, if the row has one
	bit           cur_pinned;
	list_result_t cur_pin;

	int  ops_taken;
	int  results_seen;
	int  full_answers;
	int  range_answers;
	int  fails;
	bit  growing;

	// apply one operation to the model list and work out its answer
	function automatic list_result_t apply_list_op(logic [KIND_W-1:0] op,
		logic [IDX_W-1:0] pos, logic [DATA_WIDTH-1:0] data);
		list_result_t res;
		int           i;
		res        = '0;
		res.status = ST_OK;
		case (op)
			KIND_INSERT: begin
				if (list_len >= DEPTH) begin
					res.status = ST_FULL;
				end else if (int'(pos) > list_len) begin
					res.status = ST_RANGE;
				end else begin
					for (i = list_len; i > int'(pos); i--)
						list_mem[i] = list_mem[i-1];
					list_mem[pos] = data;
					list_len++;
				end
			end
			KIND_REMOVE: begin
				if (int'(pos) >= list_len) begin
					res.status = ST_RANGE;
				end else begin
					for (i = int'(pos); i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
				end
			end
			KIND_READ: begin
				if (int'(pos) >= list_len)
					res.status = ST_RANGE;
				else
					res.read_value = list_mem[pos];
			end
			default: begin
				res.status = ST_RANGE;
			end
		endcase
		res.count     = IDX_W'(list_len);
		res.empty_res = (list_len == 0);
		return res;
	endfunction

	// both sides run flat out inside the quiet window
	function automatic bit quiet_window();
		return ops_taken >= QUIET_FIRST && ops_taken < QUIET_LAST;
	endfunction

	// ------------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------------
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------------
	// Transfer monitor: drain results against the store, then log the new
	// operation into the model. A result always belongs to an operation taken
	// at an earlier edge, so check before push.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		list_result_t model_ans;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				got.read_value = rsp_if.read_value;
				got.status     = status_t'(rsp_if.status);
				got.count      = rsp_if.count;
				got.empty_res  = rsp_if.empty_res;
				results_seen++;
				if (got.status == ST_FULL)
					full_answers++;
				if (got.status == ST_RANGE)
					range_answers++;
				if (pending_results.size() == 0) begin
					$error("result transfer with no operation outstanding");
					fails++;
				end else begin
					want = pending_results.pop_front();
					if (got.read_value !== want.read_value) begin
						$error("read_value: expected %h, got %h",
							want.read_value, got.read_value);
						fails++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						fails++;
					end
					if (got.count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, got.count);
						fails++;
					end
					if (got.empty_res !== want.empty_res) begin
						$error("empty_res: expected %b, got %b",
							want.empty_res, got.empty_res);
						fails++;
					end
				end
			end
			if (req_if.valid && req_if.ready) begin
				// always advance the model; a pinned row overrides its answer
				model_ans = apply_list_op(req_if.kind, req_if.index, req_if.value);
				pending_results.push_back(cur_pinned ? cur_pin : model_ans);
				ops_taken++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result side: random stalls, a quiet window, and one long hold-off so the
	// result register fills and the block stalls its request side.
	// ------------------------------------------------------------------------
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left      = 0;
		hold_done      = 1'b0;
		rsp_if.ready   = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && ops_taken >= HOLD_TRIGGER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_if.ready <= 1'b0;
				hold_left--;
			end else if (quiet_window()) begin
				rsp_if.ready <= 1'b1;
			end else begin
				rsp_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------

	// offer one operation from a falling edge; return at the falling edge
	// after its transfer
	task automatic offer_op(logic [KIND_W-1:0] op, logic [IDX_W-1:0] pos,
		logic [DATA_WIDTH-1:0] data, bit pinned, list_result_t pin);
		while (!quiet_window() && $urandom_range(0, 99) < IDLE_PCT) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		cur_pinned   = pinned;
		cur_pin      = pin;
		req_if.valid <= 1'b1;
		req_if.kind  <= op;
		req_if.index <= pos;
		req_if.value <= data;
		// hold until the block takes it
		do
			@(posedge clk);
		while (!req_if.ready);
		@(negedge clk);
	endtask

	// Mostly well-formed operations at legal indices, steered so the list
	// sweeps between empty and full; the rest is noise at any index and the
	// unused kind code.
	task automatic pick_random_op(output logic [KIND_W-1:0] op,
		output logic [IDX_W-1:0] pos, output logic [DATA_WIDTH-1:0] data);
		int unsigned roll;
		int unsigned mix;
		if (list_len >= DEPTH)
			growing = 1'b0;
		else if (list_len == 0)
			growing = 1'b1;
		roll = $urandom_range(0, 99);
		mix  = $urandom_range(0, 9);
		data = (mix == 0) ? '0 : (mix == 1) ? '1 : DATA_WIDTH'($urandom);
		if (roll < 4) begin
			op  = KIND_UNUSED;
			pos = IDX_W'($urandom_range(0, 31));
		end else if (roll < 12) begin
			op  = KIND_W'($urandom_range(0, 2));
			pos = IDX_W'($urandom_range(0, 31));
		end else begin
			roll = $urandom_range(0, 99);
			if (list_len == 0)
				op = KIND_INSERT;
			else if (roll < (growing ? 55 : 20))
				op = KIND_INSERT;
			else if (roll < 75)
				op = KIND_REMOVE;
			else
				op = KIND_READ;
			if (op == KIND_INSERT)
				pos = IDX_W'($urandom_range(0, list_len));
			else
				pos = IDX_W'($urandom_range(0, list_len - 1));
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [KIND_W-1:0]     op;
		logic [IDX_W-1:0]      pos;
		logic [DATA_WIDTH-1:0] data;
		list_op_t              row;

		req_if.valid  = 1'b0;
		req_if.kind   = KIND_INSERT;
		req_if.index  = '0;
		req_if.value  = '0;
		cur_pinned    = 1'b0;
		cur_pin       = '0;
		list_len      = 0;
		ops_taken     = 0;
		results_seen  = 0;
		full_answers  = 0;
		range_answers = 0;
		fails         = 0;
		growing       = 1'b1;
		for (int i = 0; i < DEPTH; i++)
			list_mem[i] = '0;

		// hold reset, then release it on a falling edge
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_ops[n]) begin
			row = directed_ops[n];
			offer_op(row.kind, row.index, row.value, row.pinned, row.pin);
		end

		for (int n = 0; n < RANDOM_OPS; n++) begin
			pick_random_op(op, pos, data);
			offer_op(op, pos, data, 1'b0, '0);
		end
		req_if.valid <= 1'b0;

		// drain outstanding results, then idle before the summary
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("Covered %0d operations (%0d from the table) and checked %0d results,",
			ops_taken, DIRECTED_OPS, results_seen);
		$display("of which %0d hit a full list and %0d an out-of-range index.",
			full_answers, range_answers);
		if (fails == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
rtl/isa_pkg.sv
rtl/isa_req_if.sv
rtl/isa_rsp_if.sv
rtl/isa_cell.sv
rtl/indexed_shift_array_core.sv
sim/indexed_shift_array_core_tb.sv
